>>> hw/rtl/adc_sensor_fault_monitor_core_defines.svh
// ----------------------------------------------------------------------------
// ADC sensor fault monitor assertion macros
// Shared clocked assertion forms for the monitor checkers.
// ----------------------------------------------------------------------------
`ifndef ADC_SENSOR_FAULT_MONITOR_CORE_DEFINES_SVH
`define ADC_SENSOR_FAULT_MONITOR_CORE_DEFINES_SVH

// same-cycle implication
`define ASFM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("asfm assertion failed");

// next-cycle implication
`define ASFM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("asfm assertion failed");

`endif

>>> hw/rtl/asfm_pkg.sv
// ----------------------------------------------------------------------------
// asfm_pkg
// Types and constants of the ADC sensor fault monitor.
// ----------------------------------------------------------------------------
package asfm_pkg;

	localparam int CELLS_DEFAULT = 8;
	localparam int CELL_W        = 4;
	localparam int SAMPLE_W      = 12;
	localparam int CFG_IDX_W     = 3;

	localparam logic [SAMPLE_W-1:0] JUMP_DELTA_RST  = 12'd800;
	localparam logic [SAMPLE_W-1:0] RAIL_LOW_RST    = 12'd5;
	localparam logic [SAMPLE_W-1:0] RAIL_HIGH_RST   = 12'd4090;
	localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST   = 12'd0;
	localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST  = 12'd4095;

	localparam logic [1:0] JUMP_LIMIT   = 2'd3;
	localparam logic [3:0] FROZEN_LIMIT = 4'd10;
	localparam logic [4:0] RAIL_LIMIT   = 5'd20;
	localparam logic [3:0] RANGE_LIMIT  = 4'd10;

	typedef enum logic [2:0] {
		CAUSE_NONE   = 3'd0,
		CAUSE_JUMP   = 3'd1,
		CAUSE_FROZEN = 3'd2,
		CAUSE_RAIL   = 3'd3,
		CAUSE_RANGE  = 3'd4
	} cause_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JUMP_DELTA = 3'd0,
		REG_RAIL_LOW   = 3'd1,
		REG_RAIL_HIGH  = 3'd2,
		REG_RANGE_LOW  = 3'd3,
		REG_RANGE_HIGH = 3'd4,
		REG_FROZEN_EN  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] jump_delta;
		logic [SAMPLE_W-1:0] rail_low;
		logic [SAMPLE_W-1:0] rail_high;
		logic [SAMPLE_W-1:0] range_low;
		logic [SAMPLE_W-1:0] range_high;
		logic                frozen_en;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] filt;
		logic                filt_valid;
		logic [SAMPLE_W-1:0] prev;
		logic                prev_valid;
		logic [1:0]          jump_run;
		logic [3:0]          frozen_run;
		logic [4:0]          rail_run;
		logic [3:0]          range_run;
	} cell_state_t;

endpackage

>>> hw/rtl/adc_sensor_fault_monitor_core.sv
// ----------------------------------------------------------------------------
// adc_sensor_fault_monitor_core
// Per-cell converter fault monitor: filter, jump, frozen, rail and range runs.
// ----------------------------------------------------------------------------
// Flow: an accepted request lands in the input register, and the cell update closes
// into the result register once the output is free or its result is taken.
// Throughput: one request per cycle while the output is not stalled; the per-cell
// state update is combinational, so back-to-back requests to the same cell need no stall.
// Reset: all cell state, the pass flag, the config registers and the valid flags return to defaults.
module adc_sensor_fault_monitor_core import asfm_pkg::*; #(
	parameter int CELLS = CELLS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CELL_W-1:0]    cell_index,
	input  logic [SAMPLE_W-1:0]  raw_sample,
	input  logic [SAMPLE_W-1:0]  voltage_sample,
	input  logic                 in_startup,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 pass_fault,
	output logic [2:0]           fault_cause,
	output logic                 skipped,
	output logic [SAMPLE_W-1:0]  filtered_out
);

	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [CELL_W:0] CELLS_LIM = (CELL_W+1)'(CELLS);

	cfg_t                cfg_q;
	cell_state_t         cells_q [CELLS];
	logic                pass_faulted_q;

	logic                valid_s1;
	logic [CELL_W-1:0]   cell_s1;
	logic [SAMPLE_W-1:0] raw_s1;
	logic [SAMPLE_W-1:0] volt_s1;
	logic                startup_s1;

	logic                out_valid_q;
	logic                pass_fault_q;
	cause_t              cause_q;
	logic                skipped_q;
	logic [SAMPLE_W-1:0] filt_out_q;

	logic                advance;
	logic                in_range;
	logic [IDX_W-1:0]    idx;
	cell_state_t         cur;
	cell_state_t         nxt;
	cause_t              cell_cause;
	logic                pf_base;
	logic                run;
	logic                pf_next;
	logic [SAMPLE_W-1:0] filt_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jump_delta <= JUMP_DELTA_RST;
			cfg_q.rail_low   <= RAIL_LOW_RST;
			cfg_q.rail_high  <= RAIL_HIGH_RST;
			cfg_q.range_low  <= RANGE_LOW_RST;
			cfg_q.range_high <= RANGE_HIGH_RST;
			cfg_q.frozen_en  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_JUMP_DELTA: cfg_q.jump_delta <= cfg_data;
				REG_RAIL_LOW:   cfg_q.rail_low   <= cfg_data;
				REG_RAIL_HIGH:  cfg_q.rail_high  <= cfg_data;
				REG_RANGE_LOW:  cfg_q.range_low  <= cfg_data;
				REG_RANGE_HIGH: cfg_q.range_high <= cfg_data;
				REG_FROZEN_EN:  cfg_q.frozen_en  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cell_s1    <= cell_index;
			raw_s1     <= raw_sample;
			volt_s1    <= voltage_sample;
			startup_s1 <= in_startup;
		end
	end

	assign in_range = {1'b0, cell_s1} < CELLS_LIM;
	assign idx      = in_range ? cell_s1[IDX_W-1:0] : '0;
	assign cur      = cells_q[idx];

	asfm_cell_judge u_judge (
		.cur   (cur),
		.cfg   (cfg_q),
		.raw   (raw_s1),
		.volt  (volt_s1),
		.nxt   (nxt),
		.cause (cell_cause)
	);

	assign pf_base = (cell_s1 == '0) ? 1'b0 : pass_faulted_q;
	assign run     = in_range && !startup_s1 && !pf_base;

	always_comb begin
		if (!in_range) begin
			pf_next  = pass_faulted_q;
			filt_res = '0;
		end else if (startup_s1) begin
			pf_next  = 1'b0;
			filt_res = cur.filt;
		end else begin
			pf_next  = run ? (cell_cause != CAUSE_NONE) : pf_base;
			filt_res = run ? nxt.filt : cur.filt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				cells_q[i] <= '0;
			end
			pass_faulted_q <= 1'b0;
		end else if (advance) begin
			if (run) begin
				cells_q[idx] <= nxt;
			end
			pass_faulted_q <= pf_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pass_fault_q <= pf_next;
			cause_q      <= run ? cell_cause : CAUSE_NONE;
			skipped_q    <= !run;
			filt_out_q   <= filt_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign pass_fault   = pass_fault_q;
	assign fault_cause  = cause_q;
	assign skipped      = skipped_q;
	assign filtered_out = filt_out_q;

endmodule

>>> hw/rtl/asfm_cell_judge.sv
// ----------------------------------------------------------------------------
// asfm_cell_judge
// One-cell step: filter update and the four saturating fault run counters.
// ----------------------------------------------------------------------------
module asfm_cell_judge import asfm_pkg::*; (
	input  cell_state_t         cur,
	input  cfg_t                cfg,
	input  logic [SAMPLE_W-1:0] raw,
	input  logic [SAMPLE_W-1:0] volt,
	output cell_state_t         nxt,
	output cause_t              cause
);

	logic [SAMPLE_W+1:0] f_sum;
	logic [SAMPLE_W-1:0] f;
	logic [SAMPLE_W-1:0] diff;
	logic                jump_hit, frozen_hit, rail_hit, range_hit;
	logic [1:0]          jr_inc, jr_new;
	logic [3:0]          fr_inc, fr_new;
	logic [4:0]          rl_inc, rl_new;
	logic [3:0]          rg_inc, rg_new;
	logic                jump_fault, frozen_fault, rail_fault, range_fault;
	logic                checks_ok;

	assign f_sum = {2'b00, cur.filt} + {1'b0, cur.filt, 1'b0} + {2'b00, raw};
	assign f     = cur.filt_valid ? f_sum[SAMPLE_W+1:2] : raw;
	assign diff  = (f >= cur.prev) ? (f - cur.prev) : (cur.prev - f);

	assign jump_hit   = diff > cfg.jump_delta;
	assign frozen_hit = cfg.frozen_en && (diff <= 12'd1);
	assign rail_hit   = (f <= cfg.rail_low) || (f >= cfg.rail_high);
	assign range_hit  = (volt < cfg.range_low) || (volt > cfg.range_high);

	assign jr_inc = (cur.jump_run < JUMP_LIMIT) ? cur.jump_run + 2'd1 : cur.jump_run;
	assign fr_inc = (cur.frozen_run < FROZEN_LIMIT) ? cur.frozen_run + 4'd1 : cur.frozen_run;
	assign rl_inc = (cur.rail_run < RAIL_LIMIT) ? cur.rail_run + 5'd1 : cur.rail_run;
	assign rg_inc = (cur.range_run < RANGE_LIMIT) ? cur.range_run + 4'd1 : cur.range_run;

	assign jr_new = jump_hit ? jr_inc : 2'd0;
	assign fr_new = frozen_hit ? fr_inc : 4'd0;
	assign rl_new = rail_hit ? rl_inc : 5'd0;
	assign rg_new = range_hit ? rg_inc : 4'd0;

	assign jump_fault   = jump_hit && (jr_inc >= JUMP_LIMIT);
	assign frozen_fault = frozen_hit && (fr_inc >= FROZEN_LIMIT);
	assign rail_fault   = rail_hit && (rl_inc >= RAIL_LIMIT);
	assign range_fault  = range_hit && (rg_inc >= RANGE_LIMIT);

	always_comb begin
		nxt            = cur;
		nxt.filt       = f;
		nxt.filt_valid = 1'b1;
		cause          = CAUSE_NONE;
		checks_ok      = 1'b1;
		if (cur.prev_valid) begin
			nxt.jump_run = jr_new;
			if (jump_fault) begin
				cause     = CAUSE_JUMP;
				checks_ok = 1'b0;
			end else begin
				nxt.frozen_run = fr_new;
				if (frozen_fault) begin
					cause     = CAUSE_FROZEN;
					checks_ok = 1'b0;
				end
			end
		end
		if (checks_ok) begin
			nxt.prev       = f;
			nxt.prev_valid = 1'b1;
			nxt.rail_run   = rl_new;
			if (rail_fault) begin
				cause = CAUSE_RAIL;
			end else begin
				nxt.range_run = rg_new;
				if (range_fault) begin
					cause = CAUSE_RANGE;
				end
			end
		end
	end

endmodule

>>> hw/rtl/asfm_checker.sv
// ----------------------------------------------------------------------------
// asfm_checker
// Port-level checks on the fault monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "adc_sensor_fault_monitor_core_defines.svh"

module asfm_checker import asfm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 pass_fault,
	input logic [2:0]           fault_cause,
	input logic                 skipped,
	input logic [SAMPLE_W-1:0]  filtered_out
);

	logic [SAMPLE_W+4:0] res_w;

	assign res_w = {pass_fault, fault_cause, skipped, filtered_out};

	// stalled result holds
	`ASFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_w))

	// a declared fault raises the pass flag and comes from a judged sample
	`ASFM_ASSERT_NOW(a_fault_flag, out_valid && fault_cause != CAUSE_NONE, pass_fault && !skipped)

	// skipped samples never declare a fault
	`ASFM_ASSERT_NOW(a_skip_clean, out_valid && skipped, fault_cause == CAUSE_NONE)

	// with a free output, a waiting request is always taken
	`ASFM_ASSERT_NOW(a_no_block, !out_valid, in_ready)

endmodule

bind adc_sensor_fault_monitor_core asfm_checker u_asfm_checker (.*);
